FILE: hw/rtl/hvd_pkg.sv
// ----------------------------------------------------------------------------
// HMM Viterbi decoder package
// Shared types, codes and default sizes for the decoder controller and
// datapath.
// ----------------------------------------------------------------------------
package hvd_pkg;

  localparam int DEF_MAX_STATES = 32;
  localparam int DEF_MAX_STEPS  = 4096;
  localparam int DEF_SCORE_BITS = 32;

  // Widths of the command fields, sized for the largest configuration.
  localparam int IDX_W  = 6;
  localparam int STEP_W = 17;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_TRANS   = 3'd1,
    OP_EMIT    = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_FINISH  = 3'd4,
    OP_TRACE   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    K_INIT = 2'd0,
    K_MAX  = 2'd1,
    K_FIN  = 2'd2,
    K_COPY = 2'd3
  } kind_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [IDX_W-1:0]  i;
    logic [IDX_W-1:0]  j;
    logic              first;
    logic              last;
  } pipe_cmd_t;

  typedef struct packed {
    pipe_cmd_t         pc;
    logic              ld_start;
    logic              ld_trans;
    logic              ld_emit;
    logic              trace_out;
    logic              trace_rd;
    logic [STEP_W-1:0] step;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cursor_zero;
  } dp_stat_t;

endpackage

FILE: hw/rtl/hvd_dpath.sv
// ----------------------------------------------------------------------------
// HMM Viterbi decoder datapath
// Score memories, backpointer memory, the four-stage max-plus pipeline,
// trace registers and the result register.
// ----------------------------------------------------------------------------
module hvd_dpath #(
  parameter int MAX_STATES = 32,
  parameter int MAX_STEPS  = 4096,
  parameter int SCORE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hvd_pkg::ctl_cmd_t       ctl,
  output hvd_pkg::dp_stat_t       stat,
  input  logic [4:0]              in_from_state,
  input  logic [4:0]              in_to_state,
  input  logic signed [31:0]      in_score,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [4:0]              out_path_state,
  output logic [11:0]             out_path_step,
  output logic signed [31:0]      out_final_score,
  output logic                    out_last
);
  import hvd_pkg::*;

  localparam int SB       = SCORE_BITS;
  localparam int SW       = $clog2(MAX_STATES);
  localparam int CW       = $clog2(MAX_STEPS);
  localparam int TR_DEPTH = 1 << (2 * SW);
  localparam int BP_DEPTH = MAX_STEPS << SW;
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                   input logic signed [SB-1:0] b);
    logic signed [SB:0] s;
    s = {a[SB-1], a} + {b[SB-1], b};
    if (s[SB] != s[SB-1]) sat_add = s[SB] ? SMIN : SMAX;
    else                  sat_add = s[SB-1:0];
  endfunction

  logic signed [SB-1:0] ps_mem [0:MAX_STATES-1];
  logic signed [SB-1:0] nx_mem [0:MAX_STATES-1];
  logic signed [SB-1:0] em_mem [0:MAX_STATES-1];
  logic signed [SB-1:0] tr_mem [0:TR_DEPTH-1];
  logic [SW-1:0]        bp_mem [0:BP_DEPTH-1];

  logic signed [SB-1:0] ld_score;
  logic                 to_ok, from_ok;
  logic [SW-1:0]        to_idx, from_idx, pi, pj, em_addr;

  logic signed [SB-1:0] ps_q, nx_q, em_q, tr_q;
  logic [SW-1:0]        bp_q;
  pipe_cmd_t            p1_r, p2_r, p3_r;
  logic signed [SB-1:0] s2_r, em2_r, em3_r, s2_nxt;
  logic signed [SB-1:0] best_r;
  logic [SW-1:0]        arg_r;
  logic [SW-1:0]        tstate_r;
  logic [CW-1:0]        tcur_r, fin_cur;
  logic                 out_valid_r;
  logic [4:0]           out_state_r;
  logic [11:0]          out_step_r;
  logic signed [31:0]   out_score_r;
  logic                 out_last_r;

  // Load scores are narrowed to the score width with saturation when it is below 32 bits.
  generate
    if (SB >= 32) begin : g_wide
      assign ld_score = SB'(in_score);
    end else begin : g_narrow
      always_comb begin
        if (&in_score[31:SB-1] || ~|in_score[31:SB-1]) ld_score = in_score[SB-1:0];
        else ld_score = in_score[31] ? SMIN : SMAX;
      end
    end
  endgenerate

  assign to_ok    = int'(in_to_state) < MAX_STATES;
  assign from_ok  = int'(in_from_state) < MAX_STATES;
  assign to_idx   = SW'(in_to_state);
  assign from_idx = SW'(in_from_state);
  assign pi       = SW'(ctl.pc.i);
  assign pj       = SW'(ctl.pc.j);
  assign em_addr  = (ctl.pc.kind == K_INIT) ? pi : pj;
  assign fin_cur  = CW'(ctl.step - 1'b1);

  // Path score memory: loads, and the copy-back of the new scores.
  always_ff @(posedge clk) begin
    if (ctl.ld_start && to_ok) begin
      ps_mem[to_idx] <= ld_score;
    end else if (p1_r.valid && p1_r.kind == K_COPY) begin
      ps_mem[SW'(p1_r.j)] <= nx_q;
    end
    ps_q <= ps_mem[pi];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_emit && to_ok) begin
      em_mem[to_idx] <= ld_score;
    end
    em_q <= em_mem[em_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_trans && to_ok && from_ok) begin
      tr_mem[{from_idx, to_idx}] <= ld_score;
    end
    tr_q <= tr_mem[{pi, pj}];
  end

  always_ff @(posedge clk) begin
    if (p3_r.valid && p3_r.last && (p3_r.kind == K_MAX || p3_r.kind == K_INIT)) begin
      nx_mem[SW'(p3_r.j)] <= sat_add(best_r, em3_r);
    end
    nx_q <= nx_mem[pj];
  end

  always_ff @(posedge clk) begin
    if (p3_r.valid && p3_r.last && p3_r.kind == K_MAX) begin
      bp_mem[{ctl.step[CW-1:0], SW'(p3_r.j)}] <= arg_r;
    end
    bp_q <= bp_mem[{tcur_r, tstate_r}];
  end

  always_comb begin
    if (p1_r.kind == K_MAX) s2_nxt = sat_add(ps_q, tr_q);
    else                    s2_nxt = ps_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.valid <= 1'b0;
      p2_r.valid <= 1'b0;
      p3_r.valid <= 1'b0;
    end else begin
      p1_r <= ctl.pc;
      p2_r <= p1_r;
      p3_r <= p2_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r  <= s2_nxt;
    em2_r <= em_q;
    em3_r <= em2_r;
    // Strictly greater keeps the lowest index on ties.
    if (p2_r.valid && p2_r.kind != K_COPY && (p2_r.first || s2_r > best_r)) begin
      best_r <= s2_r;
      arg_r  <= SW'(p2_r.i);
    end
  end

  always_ff @(posedge clk) begin
    if (p3_r.valid && p3_r.last && p3_r.kind == K_FIN) begin
      tstate_r <= arg_r;
      tcur_r   <= fin_cur;
    end else if (ctl.trace_rd && tcur_r != '0) begin
      tstate_r <= bp_q;
      tcur_r   <= tcur_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p3_r.valid && p3_r.last && p3_r.kind == K_FIN) begin
      out_valid_r <= 1'b1;
    end else if (ctl.trace_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_r.valid && p3_r.last && p3_r.kind == K_FIN) begin
      out_state_r <= 5'(arg_r);
      out_step_r  <= 12'(fin_cur);
      out_score_r <= 32'(best_r);
      out_last_r  <= 1'b0;
    end else if (ctl.trace_out) begin
      out_state_r <= 5'(tstate_r);
      out_step_r  <= 12'(tcur_r);
      out_score_r <= '0;
      out_last_r  <= (tcur_r == '0);
    end
  end

  assign stat.out_free    = !out_valid_r || out_ready;
  assign stat.cursor_zero = (tcur_r == '0);

  assign out_valid       = out_valid_r;
  assign out_path_state  = out_state_r;
  assign out_path_step   = out_step_r;
  assign out_final_score = out_score_r;
  assign out_last        = out_last_r;

endmodule

FILE: hw/rtl/hvd_ctrl.sv
// ----------------------------------------------------------------------------
// HMM Viterbi decoder controller
// Accepts requests, holds the state count and step count, and sequences
// the datapath through advance, copy-back, finish and trace.
// ----------------------------------------------------------------------------
module hvd_ctrl #(
  parameter int MAX_STATES = 32,
  parameter int MAX_STEPS  = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_operation,
  input  logic                    cfg_wr_en,
  input  logic [5:0]              cfg_wr_data,
  input  hvd_pkg::dp_stat_t       stat,
  output hvd_pkg::ctl_cmd_t       ctl
);
  import hvd_pkg::*;

  localparam int SW  = $clog2(MAX_STATES);
  localparam int KW  = $clog2(MAX_STATES + 1);
  localparam int SCW = $clog2(MAX_STEPS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_COPY  = 5'b01000,
    S_TRACE = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  kind_t          kind_r, kind_nxt;
  logic [SW-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [SCW-1:0] step_r, step_nxt;
  logic           tv_r, tv_nxt;
  logic [5:0]     ns_r;
  logic [KW-1:0]  k_act;
  logic           accept, i_end, j_end;
  op_t            op;

  always_comb begin
    if (ns_r == '0)                  k_act = KW'(1);
    else if (int'(ns_r) > MAX_STATES) k_act = KW'(MAX_STATES);
    else                             k_act = KW'(ns_r);
  end

  assign op       = op_t'(in_operation);
  assign in_ready = (state_r == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;
  assign i_end    = (KW'(i_r) == k_act - 1'b1);
  assign j_end    = (KW'(j_r) == k_act - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r <= 6'd21;
    end else if (cfg_wr_en) begin
      ns_r <= cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    tv_nxt    = tv_r;
    ctl       = '0;
    ctl.step  = STEP_W'(step_r);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_START: ctl.ld_start = 1'b1;
            OP_TRANS: ctl.ld_trans = 1'b1;
            OP_EMIT:  ctl.ld_emit  = 1'b1;
            OP_ADVANCE: begin
              tv_nxt = 1'b0;
              if (step_r < SCW'(MAX_STEPS)) begin
                kind_nxt  = (step_r == '0) ? K_INIT : K_MAX;
                i_nxt     = '0;
                j_nxt     = '0;
                state_nxt = S_RUN;
              end
            end
            OP_FINISH: begin
              if (step_r != '0) begin
                kind_nxt  = K_FIN;
                i_nxt     = '0;
                state_nxt = S_RUN;
              end
            end
            OP_TRACE: begin
              if (tv_r) begin
                ctl.trace_out = 1'b1;
                if (stat.cursor_zero) tv_nxt = 1'b0;
                state_nxt = S_TRACE;
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        ctl.pc.valid = 1'b1;
        ctl.pc.kind  = kind_r;
        ctl.pc.i     = IDX_W'(i_r);
        ctl.pc.j     = IDX_W'(j_r);
        if (kind_r == K_INIT) begin
          // The first step has no predecessor: one term per state.
          ctl.pc.i     = IDX_W'(j_r);
          ctl.pc.first = 1'b1;
          ctl.pc.last  = 1'b1;
          j_nxt = j_r + 1'b1;
          if (j_end) begin
            cnt_nxt   = 2'd3;
            state_nxt = S_DRAIN;
          end
        end else begin
          ctl.pc.first = (i_r == '0);
          ctl.pc.last  = i_end;
          if (!i_end) begin
            i_nxt = i_r + 1'b1;
          end else begin
            i_nxt = '0;
            j_nxt = j_r + 1'b1;
            if (kind_r == K_FIN || j_end) begin
              cnt_nxt   = 2'd3;
              state_nxt = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          priority case (kind_r)
            K_FIN: begin
              step_nxt  = '0;
              tv_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end
            K_COPY: begin
              step_nxt  = step_r + 1'b1;
              state_nxt = S_IDLE;
            end
            default: begin
              kind_nxt  = K_COPY;
              j_nxt     = '0;
              state_nxt = S_COPY;
            end
          endcase
        end
      end
      S_COPY: begin
        ctl.pc.valid = 1'b1;
        ctl.pc.kind  = K_COPY;
        ctl.pc.j     = IDX_W'(j_r);
        j_nxt = j_r + 1'b1;
        if (j_end) begin
          cnt_nxt   = 2'd3;
          state_nxt = S_DRAIN;
        end
      end
      S_TRACE: begin
        ctl.trace_rd = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_INIT;
      i_r     <= '0;
      j_r     <= '0;
      cnt_r   <= '0;
      step_r  <= '0;
      tv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      tv_r    <= tv_nxt;
    end
  end

  a_max_has_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && kind_r == K_MAX) |-> (step_r != '0 && step_r < SCW'(MAX_STEPS)))
    else $error("max-plus pass started without a prior step");

  a_trace_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.trace_out |-> tv_r)
    else $error("trace result without a running trace");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && cnt_r == '0 && kind_r == K_FIN) |=> (step_r == '0 && tv_r))
    else $error("finish did not clear the step count and start a trace");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("request taken while a pass is running");

endmodule

FILE: hw/rtl/hmm_viterbi_decoder.sv
// ----------------------------------------------------------------------------
// HMM Viterbi decoder
// Log-domain max-plus Viterbi decoder with per-step transition scores.
// ----------------------------------------------------------------------------
// Each load request (start, transition, emission) writes one score memory.
// An advance walks every (source, target) pair of the K states in use
// through a four-stage add/compare pipeline, one pair per cycle, then copies
// the K new scores back; the first advance of a sequence takes one term per
// state instead. A finish scans K states, and a trace request passes through
// a trace state for the registered backpointer read. The memory needs no
// clearing after reset. A result waits in an output register, and no request
// is taken while that register holds a result that the receiver is not taking
// in the same cycle.
module hmm_viterbi_decoder
  import hvd_pkg::*;
#(
  parameter int MAX_STATES = DEF_MAX_STATES,
  parameter int MAX_STEPS  = DEF_MAX_STEPS,
  parameter int SCORE_BITS = DEF_SCORE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic [4:0]         in_from_state,
  input  logic [4:0]         in_to_state,
  input  logic signed [31:0] in_score,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_path_state,
  output logic [11:0]        out_path_step,
  output logic signed [31:0] out_final_score,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [5:0]         cfg_wr_data
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  hvd_ctrl #(
    .MAX_STATES (MAX_STATES),
    .MAX_STEPS  (MAX_STEPS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .stat         (stat),
    .ctl          (ctl)
  );

  hvd_dpath #(
    .MAX_STATES (MAX_STATES),
    .MAX_STEPS  (MAX_STEPS),
    .SCORE_BITS (SCORE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_from_state   (in_from_state),
    .in_to_state     (in_to_state),
    .in_score        (in_score),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_path_state  (out_path_state),
    .out_path_step   (out_path_step),
    .out_final_score (out_final_score),
    .out_last        (out_last)
  );

endmodule

FILE: bench/hmm_viterbi_decoder_tb.sv
// ----------------------------------------------------------------------------
// HMM Viterbi decoder testbench
// Feeds score loads, advances, finishes and traces through the request
// channel, predicts every finish and trace result with a behavioral max-plus
// decoder, and compares the results field by field under random backpressure.
// ----------------------------------------------------------------------------
module hmm_viterbi_decoder_tb;
  import hvd_pkg::*;

  localparam int NS = 32;
  localparam int NSTEPS = 4096;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]         operation;
    logic [4:0]         from_state;
    logic [4:0]         to_state;
    logic signed [31:0] score;
  } request_t;

  typedef struct packed {
    logic [4:0]         path_state;
    logic [11:0]        path_step;
    logic signed [31:0] final_score;
    logic               last;
  } path_result_t;

  // A request with operation code 7 in this queue is a marker: the driver
  // holds until every expected result has come, then writes the state count.
  localparam logic [2:0] OP_CFG_MARK = 3'd7;
  // Operation code 6 does nothing in the block.
  localparam logic [2:0] OP_NOP = 3'd6;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_operation;
  logic [4:0]         in_from_state;
  logic [4:0]         in_to_state;
  logic signed [31:0] in_score;
  logic               out_valid;
  logic               out_ready;
  logic [4:0]         out_path_state;
  logic [11:0]        out_path_step;
  logic signed [31:0] out_final_score;
  logic               out_last;
  logic               cfg_wr_en;
  logic [5:0]         cfg_wr_data;

  request_t     pending_requests[$];
  path_result_t expected_paths[$];

  // Predictor state.
  int unsigned  k_states;
  logic signed [31:0] path_score[NS];
  logic signed [31:0] trans_score[NS*NS];
  logic signed [31:0] emit_score[NS];
  logic [4:0]   backptr[NSTEPS*NS];
  int unsigned  advance_count;
  int unsigned  trace_step;
  logic [4:0]   trace_st;
  logic         tracing;

  int unsigned  error_count;
  int unsigned  result_count;
  int unsigned  request_count;
  int unsigned  idle_cycles;
  int unsigned  burst_left;
  int unsigned  gap_left;
  int unsigned  drain_wait;
  int unsigned  stall_phase;
  bit           stimulus_done;

  hmm_viterbi_decoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_from_state  (in_from_state),
    .in_to_state    (in_to_state),
    .in_score       (in_score),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_path_state (out_path_state),
    .out_path_step  (out_path_step),
    .out_final_score(out_final_score),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void add_request(request_t r);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic void add_expected(path_result_t res);
    expected_paths.insert(expected_paths.size(), res);
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    if (s > 34'sd2147483647) return 32'h7fffffff;
    if (s < -34'sd2147483648) return 32'h80000000;
    return s[31:0];
  endfunction

  task automatic run_advance();
    logic signed [31:0] next_score[NS];
    logic signed [31:0] best;
    logic signed [31:0] cand;
    int unsigned arg;
    tracing = 1'b0;
    if (advance_count >= NSTEPS) return;
    if (advance_count == 0) begin
      for (int i = 0; i < k_states; i++) path_score[i] = sat_add(path_score[i], emit_score[i]);
    end else begin
      for (int j = 0; j < k_states; j++) begin
        best = sat_add(path_score[0], trans_score[j]);
        arg = 0;
        for (int i = 1; i < k_states; i++) begin
          cand = sat_add(path_score[i], trans_score[i*NS + j]);
          if (cand > best) begin
            best = cand;
            arg = i;
          end
        end
        backptr[advance_count*NS + j] = arg[4:0];
        next_score[j] = sat_add(best, emit_score[j]);
      end
      for (int j = 0; j < k_states; j++) path_score[j] = next_score[j];
    end
    advance_count++;
  endtask

  task automatic predict_request(request_t r);
    path_result_t res;
    logic signed [31:0] best;
    int unsigned arg;
    case (r.operation)
      OP_START: path_score[r.to_state] = r.score;
      OP_TRANS: trans_score[r.from_state*NS + r.to_state] = r.score;
      OP_EMIT:  emit_score[r.to_state] = r.score;
      OP_ADVANCE: run_advance();
      OP_FINISH: begin
        if (advance_count != 0) begin
          best = path_score[0];
          arg = 0;
          for (int i = 1; i < k_states; i++) begin
            if (path_score[i] > best) begin
              best = path_score[i];
              arg = i;
            end
          end
          trace_step = advance_count - 1;
          trace_st = arg[4:0];
          tracing = 1'b1;
          advance_count = 0;
          res = '{arg[4:0], trace_step[11:0], best, 1'b0};
          add_expected(res);
        end
      end
      OP_TRACE: begin
        if (tracing) begin
          res = '{trace_st, trace_step[11:0], 32'sd0, trace_step == 0};
          add_expected(res);
          if (trace_step == 0) begin
            tracing = 1'b0;
          end else begin
            trace_st = backptr[trace_step*NS + trace_st];
            trace_step--;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_score();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 3)) <<< 16;
      default: return $urandom();
    endcase
  endfunction

  function automatic request_t make_req(logic [2:0] op, int unsigned f, int unsigned t,
                                        logic signed [31:0] s);
    request_t r;
    r.operation = op;
    r.from_state = f[4:0];
    r.to_state = t[4:0];
    r.score = s;
    return r;
  endfunction

  // One full sequence: load, advance for a few steps, finish, and trace.
  // Every entry that an advance or finish reads is written first.
  task automatic queue_sequence(int unsigned k, int unsigned steps, bit full_trace);
    int unsigned n_trace;
    for (int i = 0; i < k; i++) add_request(make_req(OP_START, $urandom, i, rand_score()));
    for (int s = 0; s < steps; s++) begin
      if (s > 0) begin
        for (int f = 0; f < k; f++)
          for (int t = 0; t < k; t++)
            add_request(make_req(OP_TRANS, f, t, rand_score()));
      end
      for (int i = 0; i < k; i++) add_request(make_req(OP_EMIT, $urandom, i, rand_score()));
      add_request(make_req(OP_ADVANCE, $urandom, $urandom, $urandom));
    end
    add_request(make_req(OP_FINISH, $urandom, $urandom, $urandom));
    n_trace = full_trace ? steps + 1 : $urandom_range(0, steps + 1);
    for (int i = 0; i < n_trace; i++)
      add_request(make_req(OP_TRACE, $urandom, $urandom, $urandom));
  endtask

  task automatic queue_config(int unsigned value);
    add_request(make_req(OP_CFG_MARK, 0, 0, 32'(value)));
  endtask

  initial begin
    int unsigned k;
    int unsigned cfg_values[6];
    logic [2:0]  noise_op;
    cfg_values = '{1, 2, 0, 63, 3, 5};
    // Directed part, reset count 21: a finish and a trace before anything
    // ran, codes that do nothing, and a short sequence with extreme scores.
    add_request(make_req(OP_FINISH, 31, 31, 32'h7fffffff));
    add_request(make_req(OP_TRACE, 0, 0, 32'h80000000));
    add_request(make_req(OP_NOP, 31, 0, 0));
    add_request(make_req(OP_NOP, 0, 31, -1));
    queue_config(2);
    add_request(make_req(OP_START, 0, 0, 32'h7fffffff));
    add_request(make_req(OP_START, 0, 1, 32'h7fffffff));
    add_request(make_req(OP_EMIT, 0, 0, 32'h7fffffff));
    add_request(make_req(OP_EMIT, 0, 1, 32'h80000000));
    add_request(make_req(OP_ADVANCE, 0, 0, 0));
    for (int f = 0; f < 2; f++)
      for (int t = 0; t < 2; t++)
        add_request(make_req(OP_TRANS, f, t, 32'sd0));
    add_request(make_req(OP_EMIT, 0, 0, 32'h80000000));
    add_request(make_req(OP_EMIT, 0, 1, 32'h80000000));
    add_request(make_req(OP_ADVANCE, 0, 0, 0));
    add_request(make_req(OP_FINISH, 0, 0, 0));
    add_request(make_req(OP_TRACE, 0, 0, 0));
    // An advance in the middle of a trace ends it; the next trace is silent.
    add_request(make_req(OP_ADVANCE, 0, 0, 0));
    add_request(make_req(OP_TRACE, 0, 0, 0));
    add_request(make_req(OP_FINISH, 0, 0, 0));
    // Loads to high indexes exercise every address bit.
    add_request(make_req(OP_TRANS, 31, 31, 32'h55555555));
    add_request(make_req(OP_START, 31, 31, 32'haaaaaaaa));
    add_request(make_req(OP_EMIT, 31, 31, 32'h12345678));

    // Random part: sequences across several state counts, with noise.
    for (int phase = 0; phase < 6; phase++) begin
      queue_config(cfg_values[phase]);
      k = cfg_values[phase] == 0 ? 1 : (cfg_values[phase] > 32 ? 32 : cfg_values[phase]);
      for (int n = 0; n < (k > 8 ? 1 : 3); n++) begin
        queue_sequence(k, k > 8 ? 2 : $urandom_range(1, 6), $urandom_range(0, 3) != 0);
        repeat ($urandom_range(0, 3)) begin
          noise_op = 3'($urandom_range(0, 6));
          // A stray advance would leave the next sequence reading transition
          // scores that were never loaded for the new state count.
          if (noise_op == OP_ADVANCE) noise_op = OP_FINISH;
          add_request(make_req(noise_op, $urandom, $urandom, $urandom));
        end
      end
    end
  end

  // Driver.
  always @(posedge clk) begin
    request_t r;
    bit       cfg_go;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_wr_en <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      drain_wait <= 0;
    end else begin
      cfg_go = 1'b0;
      if (in_valid && in_ready) begin
        r = '{in_operation, in_from_state, in_to_state, in_score};
        predict_request(r);
        request_count++;
      end
      if (in_valid && !in_ready) begin
        // Hold the request until it is taken.
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() == 0) begin
        in_valid <= 1'b0;
        stimulus_done <= 1'b1;
      end else if (pending_requests[0].operation == OP_CFG_MARK) begin
        in_valid <= 1'b0;
        // Wait for all results, then let an advance or scan run out.
        if (expected_paths.size() != 0 || out_valid) begin
          drain_wait <= 0;
        end else if (drain_wait < 1200) begin
          drain_wait <= drain_wait + 1;
        end else begin
          r = pending_requests.pop_front();
          cfg_go = 1'b1;
          cfg_wr_data <= r.score[5:0];
          k_states = r.score[5:0] == 0 ? 1 : (r.score[5:0] > 32 ? 32 : r.score[5:0]);
          drain_wait <= 0;
        end
      end else if (burst_left == 0) begin
        in_valid <= 1'b0;
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        r = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_operation <= r.operation;
        in_from_state <= r.from_state;
        in_to_state <= r.to_state;
        in_score <= r.score;
        burst_left <= burst_left - 1;
      end
      cfg_wr_en <= cfg_go;
    end
  end

  // Receiver stall pattern and result checker.
  always @(posedge clk) begin
    path_result_t exp_res;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_ready <= (stall_phase[9:8] == 2'd0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_paths.size() == 0) begin
          $display("%0t: unexpected result state=%0d step=%0d score=%0d last=%0b", $realtime,
                   out_path_state, out_path_step, out_final_score, out_last);
          error_count++;
        end else begin
          exp_res = expected_paths.pop_front();
          if (out_path_state !== exp_res.path_state) begin
            $display("%0t: path_state expected %0d actual %0d", $realtime,
                     exp_res.path_state, out_path_state);
            error_count++;
          end
          if (out_path_step !== exp_res.path_step) begin
            $display("%0t: path_step expected %0d actual %0d", $realtime,
                     exp_res.path_step, out_path_step);
            error_count++;
          end
          if (out_final_score !== exp_res.final_score) begin
            $display("%0t: final_score expected %0d actual %0d", $realtime,
                     exp_res.final_score, out_final_score);
            error_count++;
          end
          if (out_last !== exp_res.last) begin
            $display("%0t: last expected %0b actual %0b", $realtime,
                     exp_res.last, out_last);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("hmm_viterbi_decoder test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = '0;
    in_from_state = '0;
    in_to_state = '0;
    in_score = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    k_states = 21;
    advance_count = 0;
    trace_step = 0;
    trace_st = '0;
    tracing = 1'b0;
    error_count = 0;
    result_count = 0;
    request_count = 0;
    stimulus_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && expected_paths.size() == 0);
    repeat (1200) @(posedge clk);
    $display("Covered %0d requests and %0d finish or trace results over state counts",
             request_count, result_count);
    $display("from 1 to 32, including clamped settings, saturating scores and cut-off traces.");
    if (error_count == 0 && expected_paths.size() == 0) begin
      $display("hmm_viterbi_decoder test passed");
    end else begin
      $display("hmm_viterbi_decoder test failed");
    end
    $finish;
  end

endmodule
